/* design/sbis_pkg.sv */
// ----------------------------------------------------------------------------
// sbis_pkg: shared types and constants of the sparse byte image store
// Sizes of the page table and byte store, operation and status codes, and
// the sequencer states.
// ----------------------------------------------------------------------------
package sbis_pkg;

  localparam int MAX_PAGES    = 64;
  localparam int PAGE_BYTES   = 256;
  localparam int ADDRESS_BITS = 32;

  localparam int SLOT_W  = $clog2(MAX_PAGES);
  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int TAG_W   = ADDRESS_BITS - OFF_W;
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int BYTE_AW = SLOT_W + OFF_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TEST  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_REDUNDANT   = 3'd1,
    ST_OVERWRITTEN = 3'd2,
    ST_REFUSED     = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_DUP = 2'd0,
    REG_ALLOW_OVR = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_MARK_RD,
    S_EXEC,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] slot;
  } page_entry_t;

endpackage

/* design/sbis_in_if.sv */
// ----------------------------------------------------------------------------
// sbis_in_if: request channel of the sparse byte image store
// Valid/ready channel carrying one access item.
// ----------------------------------------------------------------------------
interface sbis_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [sbis_pkg::ADDRESS_BITS-1:0] byte_address;
  logic [7:0]                     write_byte;

  modport source (output valid, op, byte_address, write_byte, input ready);
  modport sink   (input valid, op, byte_address, write_byte, output ready);
endinterface

/* design/sbis_out_if.sv */
// ----------------------------------------------------------------------------
// sbis_out_if: result channel of the sparse byte image store
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sbis_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       was_written;
  logic [2:0] status;

  modport source (output valid, read_byte, was_written, status, input ready);
  modport sink   (input valid, read_byte, was_written, status, output ready);
endinterface

/* design/sparse_byte_image_store.sv */
// ----------------------------------------------------------------------------
// sparse_byte_image_store: paged sparse byte memory with sorted tag table
// Pages are found through a last-hit cache and a binary search of a sorted
// tag table; missing pages are inserted in order with their marks cleared while there is room.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_ch    sink       op, byte_address, write_byte
//  out_ch   source     read_byte, was_written, status
//  cfg_*    input      write enable, register index, data
//
// A cache hit passes through S_MARK_RD and S_EXEC before its result shows;
// the next item is accepted once the result is taken and S_IDLE is back.
// A search uses S_SEARCH and S_CMP per probe of the single tag table read
// port (up to 7 probes); a miss closes in S_SEARCH, and an insertion then
// moves each entry up through S_SHIFT_RD and S_SHIFT_WR, then S_INSERT.
// Reset clears the page count, the cache and the registers; no clearing pass.
// One item is in flight at a time; a stalled result holds the block.
// ----------------------------------------------------------------------------
module sparse_byte_image_store (
  input  logic                            clk,
  input  logic                            rst_n,
  sbis_in_if.sink                         in_ch,
  sbis_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sbis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbis_pkg::*;

  seq_state_t state_r, state_nxt;

  logic check_dup_r, allow_ovr_r;

  logic [1:0]         op_r,   op_nxt;
  logic [TAG_W-1:0]   tag_r,  tag_nxt;
  logic [OFF_W-1:0]   off_r,  off_nxt;
  logic [7:0]         data_r, data_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, k_r, k_nxt, count_r, count_nxt;
  logic [SLOT_W-1:0]  mid_r, mid_nxt, slot_r, slot_nxt;
  logic               lh_valid_r, lh_valid_nxt;
  logic [TAG_W-1:0]   lh_tag_r, lh_tag_nxt;
  logic [SLOT_W-1:0]  lh_slot_r, lh_slot_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         rd_r, rd_nxt;
  logic               was_r, was_nxt;
  logic [2:0]         status_r, status_nxt;

  // Memories: tag table, per-page written marks, byte store
  page_entry_t             pt_mem [MAX_PAGES];
  logic [PAGE_BYTES-1:0]   row_mem [MAX_PAGES];
  logic [7:0]              byte_mem [MAX_PAGES*PAGE_BYTES];

  page_entry_t             pt_q, pt_wdata;
  logic [SLOT_W-1:0]       pt_raddr, pt_waddr;
  logic                    pt_we;
  logic [PAGE_BYTES-1:0]   row_q, row_wdata;
  logic [SLOT_W-1:0]       row_waddr;
  logic                    row_we;
  logic [7:0]              byte_q;
  logic                    byte_we;

  logic                    accept, in_hit, found_done;
  logic [CNT_W-1:0]        mid_full, k_dec;
  logic                    was_bit;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_hit   = lh_valid_r && (lh_tag_r == in_ch.byte_address[ADDRESS_BITS-1:OFF_W]);
  assign mid_full = lo_r + ((hi_r - lo_r) >> 1);
  assign k_dec    = k_r - CNT_W'(1);
  assign found_done = (lo_r >= hi_r);
  assign was_bit  = row_q[off_r];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_byte   = rd_r;
  assign out_ch.was_written = was_r;
  assign out_ch.status      = status_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_dup_r <= 1'b0;
      allow_ovr_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHECK_DUP: check_dup_r <= cfg_data[0];
        REG_ALLOW_OVR: allow_ovr_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(in_ch.op) == OP_NONE) state_nxt = S_DONE;
          else if (in_hit)                state_nxt = S_MARK_RD;
          else                            state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!found_done)                            state_nxt = S_CMP;
        else if (count_r == CNT_W'(MAX_PAGES))      state_nxt = S_DONE;
        else if (count_r > lo_r)                    state_nxt = S_SHIFT_RD;
        else                                        state_nxt = S_INSERT;
      end
      S_CMP: begin
        if (pt_q.tag == tag_r) state_nxt = S_MARK_RD;
        else                   state_nxt = S_SEARCH;
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (k_dec > lo_r) state_nxt = S_SHIFT_RD;
        else              state_nxt = S_INSERT;
      end
      S_INSERT:  state_nxt = S_MARK_RD;
      S_MARK_RD: state_nxt = S_EXEC;
      S_EXEC:    state_nxt = S_DONE;
      S_DONE: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    op_nxt = op_r; tag_nxt = tag_r; off_nxt = off_r; data_nxt = data_r;
    lo_nxt = lo_r; hi_nxt = hi_r; k_nxt = k_r; count_nxt = count_r;
    mid_nxt = mid_r; slot_nxt = slot_r;
    lh_valid_nxt = lh_valid_r; lh_tag_nxt = lh_tag_r; lh_slot_nxt = lh_slot_r;
    out_valid_nxt = out_valid_r; rd_nxt = rd_r; was_nxt = was_r; status_nxt = status_r;
    pt_raddr = mid_r; pt_we = 1'b0; pt_waddr = k_r[SLOT_W-1:0]; pt_wdata = pt_q;
    row_we = 1'b0; row_waddr = slot_r; row_wdata = row_q;
    byte_we = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_ch.op;
          tag_nxt  = in_ch.byte_address[ADDRESS_BITS-1:OFF_W];
          off_nxt  = in_ch.byte_address[OFF_W-1:0];
          data_nxt = in_ch.write_byte;
          lo_nxt   = '0;
          hi_nxt   = count_r;
          slot_nxt = lh_slot_r;
          if (op_t'(in_ch.op) == OP_NONE) begin
            out_valid_nxt = 1'b1;
            rd_nxt = '0; was_nxt = 1'b0; status_nxt = ST_OK;
          end
        end
      end
      S_SEARCH: begin
        pt_raddr = mid_full[SLOT_W-1:0];
        mid_nxt  = mid_full[SLOT_W-1:0];
        k_nxt    = count_r;
        if (found_done && count_r == CNT_W'(MAX_PAGES)) begin
          out_valid_nxt = 1'b1;
          rd_nxt = '0; was_nxt = 1'b0; status_nxt = ST_FULL;
        end
      end
      S_CMP: begin
        if (pt_q.tag == tag_r) begin
          slot_nxt     = pt_q.slot;
          lh_valid_nxt = 1'b1;
          lh_tag_nxt   = tag_r;
          lh_slot_nxt  = pt_q.slot;
        end else if (tag_r < pt_q.tag) begin
          hi_nxt = {1'b0, mid_r};
        end else begin
          lo_nxt = {1'b0, mid_r} + CNT_W'(1);
        end
      end
      S_SHIFT_RD: begin
        pt_raddr = k_dec[SLOT_W-1:0];
      end
      S_SHIFT_WR: begin
        pt_we    = 1'b1;
        pt_waddr = k_r[SLOT_W-1:0];
        pt_wdata = pt_q;
        k_nxt    = k_dec;
      end
      S_INSERT: begin
        pt_we         = 1'b1;
        pt_waddr      = lo_r[SLOT_W-1:0];
        pt_wdata.tag  = tag_r;
        pt_wdata.slot = count_r[SLOT_W-1:0];
        row_we        = 1'b1;
        row_waddr     = count_r[SLOT_W-1:0];
        row_wdata     = '0;
        slot_nxt      = count_r[SLOT_W-1:0];
        count_nxt     = count_r + CNT_W'(1);
        lh_valid_nxt  = 1'b1;
        lh_tag_nxt    = tag_r;
        lh_slot_nxt   = count_r[SLOT_W-1:0];
      end
      S_MARK_RD: ;
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        rd_nxt = '0; was_nxt = was_bit; status_nxt = ST_OK;
        case (op_t'(op_r))
          OP_WRITE: begin
            byte_we = 1'b1;
            if (check_dup_r && was_bit) begin
              rd_nxt = byte_q;
              if (byte_q == data_r)  status_nxt = ST_REDUNDANT;
              else if (allow_ovr_r)  status_nxt = ST_OVERWRITTEN;
              else begin
                status_nxt = ST_REFUSED;
                byte_we    = 1'b0;
              end
            end
            row_we = byte_we;
            row_wdata[off_r] = 1'b1;
          end
          OP_READ: rd_nxt = was_bit ? byte_q : 8'd0;
          default: ;
        endcase
      end
      S_DONE: begin
        if (out_ch.ready) out_valid_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lh_valid_r  <= 1'b0;
      lh_tag_r    <= '0;
      lh_slot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lh_valid_r  <= lh_valid_nxt;
      lh_tag_r    <= lh_tag_nxt;
      lh_slot_r   <= lh_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; tag_r <= tag_nxt; off_r <= off_nxt; data_r <= data_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; k_r <= k_nxt; mid_r <= mid_nxt;
    slot_r <= slot_nxt;
    rd_r <= rd_nxt; was_r <= was_nxt; status_r <= status_nxt;
  end

  // Tag table: one write and one registered read port
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_q <= pt_mem[pt_raddr];
  end

  // Written marks, one row per physical page
  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    row_q <= row_mem[slot_r];
  end

  // Byte store
  always_ff @(posedge clk) begin
    if (byte_we) byte_mem[{slot_r, off_r}] <= data_r;
    byte_q <= byte_mem[{slot_r, off_r}];
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sparse byte image store
// Drives byte write, read, test and OP_NONE items through the request channel and
// predicts each result from an internal copy of the page table, byte store
// and written marks. Results are compared field by field in arrival order,
// under several duplicate-check settings and idling patterns. It also covers
// a long result stall and the page table filling up.
// ----------------------------------------------------------------------------
module tb_top;
  import sbis_pkg::*;

  localparam int  TAG_POOL      = 72;
  localparam int  DRAIN_CYCLES  = 200;
  localparam int  WATCHDOG_MAX  = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       was_written;
    logic [2:0] status;
  } access_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sbis_in_if  in_ch ();
  sbis_out_if out_ch ();

  sparse_byte_image_store uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's state.
  logic [TAG_W-1:0]  shadow_tags [MAX_PAGES];
  logic [SLOT_W-1:0] shadow_slots [MAX_PAGES];
  int                shadow_pages;
  logic              hit_valid;
  logic [TAG_W-1:0]  hit_tag;
  logic [SLOT_W-1:0] hit_slot;
  logic [7:0]        shadow_bytes [MAX_PAGES*PAGE_BYTES];
  logic              shadow_marks [MAX_PAGES*PAGE_BYTES];
  logic              check_dup;
  logic              allow_ovr;

  access_result_t    pending_results [$];
  logic [TAG_W-1:0]  tag_pool [TAG_POOL];
  int                error_count;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                recv_hold;
  int                quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mismatch reporting.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Finds the physical page of a tag, inserting it in order when missing and there is room.
  function automatic logic find_page(input logic [TAG_W-1:0] tag,
                                     output logic [SLOT_W-1:0] slot);
    int lo;
    int hi;
    int mid;
    int fresh;
    lo = 0;
    hi = shadow_pages;
    slot = '0;
    if (hit_valid && hit_tag == tag) begin
      slot = hit_slot;
      return 1'b1;
    end
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_tags[mid] == tag) begin
        hit_valid = 1'b1;
        hit_tag   = tag;
        hit_slot  = shadow_slots[mid];
        slot      = shadow_slots[mid];
        return 1'b1;
      end
      if (tag < shadow_tags[mid]) hi = mid;
      else lo = mid + 1;
    end
    if (shadow_pages >= MAX_PAGES) return 1'b0;
    fresh = shadow_pages;
    for (int k = shadow_pages; k > lo; k--) begin
      shadow_tags[k]  = shadow_tags[k-1];
      shadow_slots[k] = shadow_slots[k-1];
    end
    shadow_tags[lo]  = tag;
    shadow_slots[lo] = SLOT_W'(fresh);
    shadow_pages++;
    for (int b = 0; b < PAGE_BYTES; b++) shadow_marks[fresh*PAGE_BYTES + b] = 1'b0;
    hit_valid = 1'b1;
    hit_tag   = tag;
    hit_slot  = SLOT_W'(fresh);
    slot      = SLOT_W'(fresh);
    return 1'b1;
  endfunction

  // Works out the result of one access and updates the shadow state.
  function automatic access_result_t predict_access(input logic [1:0] op,
                                                    input logic [31:0] addr,
                                                    input logic [7:0] datum);
    access_result_t res;
    logic [SLOT_W-1:0] slot;
    int pos;
    res = '0;
    if (op == OP_NONE) return res;
    if (!find_page(addr[31:OFF_W], slot)) begin
      res.status = ST_FULL;
      return res;
    end
    pos = int'(slot) * PAGE_BYTES + int'(addr[OFF_W-1:0]);
    res.was_written = shadow_marks[pos];
    if (op == OP_WRITE) begin
      res.status = ST_OK;
      if (check_dup && shadow_marks[pos]) begin
        res.read_byte = shadow_bytes[pos];
        if (shadow_bytes[pos] == datum) res.status = ST_REDUNDANT;
        else if (allow_ovr) res.status = ST_OVERWRITTEN;
        else res.status = ST_REFUSED;
      end
      if (res.status != ST_REFUSED) begin
        shadow_bytes[pos] = datum;
        shadow_marks[pos] = 1'b1;
      end
    end else if (op == OP_READ && shadow_marks[pos]) begin
      res.read_byte = shadow_bytes[pos];
    end
    return res;
  endfunction

  // Sends one item, holding valid high across back-to-back items unless an idle gap is drawn.
  task automatic send_access(input logic [1:0] op, input logic [31:0] addr,
                             input logic [7:0] datum);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.op           = op;
    in_ch.byte_address = addr;
    in_ch.write_byte   = datum;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_access(op, addr, datum));
  endtask

  // Lowers valid and waits until every result has come back.
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic value);
    drain();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_CHECK_DUP) check_dup = value;
    else if (idx == REG_ALLOW_OVR) allow_ovr = value;
  endtask

  // Random access on a page from the first pool_size pool tags.
  task automatic send_random(input int pool_size);
    logic [1:0] op;
    logic [7:0] offset;
    logic [7:0] datum;
    op     = ($urandom_range(0, 49) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
    offset = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 7))
                                         : 8'($urandom_range(0, 255));
    datum  = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
    send_access(op, {tag_pool[$urandom_range(0, pool_size-1)], offset}, datum);
  endtask

  task automatic run_random(input int count, input int pool_size);
    for (int i = 0; i < count; i++) send_random(pool_size);
  endtask

  // Extremes of the address, every operation and the unwritten read.
  task automatic test_directed;
    send_access(OP_READ,  32'h0000_0000, 8'h00);
    send_access(OP_TEST,  32'h0000_0000, 8'h00);
    send_access(OP_WRITE, 32'h0000_0000, 8'hFF);
    send_access(OP_READ,  32'h0000_0000, 8'h00);
    send_access(OP_TEST,  32'h0000_0000, 8'h00);
    send_access(OP_WRITE, 32'hFFFF_FFFF, 8'h00);
    send_access(OP_WRITE, 32'hFFFF_FFFF, 8'hA5);
    send_access(OP_READ,  32'hFFFF_FFFF, 8'h00);
    send_access(OP_NONE,  32'h1234_5678, 8'h5A);
    send_access(OP_READ,  32'h1234_5678, 8'h00);
    send_access(OP_WRITE, 32'h8000_0080, 8'h55);
    send_access(OP_READ,  32'h8000_0080, 8'h00);
    send_access(OP_READ,  32'h0000_00FF, 8'h00);
  endtask

  // Duplicate checking with refusal, then with overwriting.
  task automatic test_duplicates;
    write_reg(REG_CHECK_DUP, 1'b1);
    send_access(OP_WRITE, 32'h0000_0000, 8'hFF);
    send_access(OP_WRITE, 32'h0000_0000, 8'h01);
    send_access(OP_READ,  32'h0000_0000, 8'h00);
    run_random(200, 40);
    write_reg(REG_ALLOW_OVR, 1'b1);
    send_access(OP_WRITE, 32'h0000_0000, 8'h01);
    send_access(OP_WRITE, 32'h0000_0000, 8'h01);
    send_access(OP_READ,  32'h0000_0000, 8'h00);
    run_random(200, 40);
    // The spare index must leave both registers alone.
    write_reg(CFG_IDX_SPARE, 1'b0);
    run_random(50, 40);
  endtask

  // Idling on either side or both.
  task automatic test_idling;
    write_reg(REG_ALLOW_OVR, 1'b0);
    send_idle_pct = 79;
    run_random(100, 40);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    run_random(100, 40);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    write_reg(REG_CHECK_DUP, 1'b0);
    run_random(100, 40);
  endtask

  // Receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    recv_hold = 400;
    run_random(20, 40);
  endtask

  // Fill the page table, then keep accessing known and missing pages.
  task automatic test_table_full;
    write_reg(REG_CHECK_DUP, 1'b1);
    write_reg(REG_ALLOW_OVR, 1'b1);
    for (int t = 0; t < TAG_POOL; t++)
      send_access(OP_WRITE, {tag_pool[t], 8'($urandom_range(0, 255))}, 8'($urandom));
    run_random(250, TAG_POOL);
  endtask

  // Receiver ready pattern, with an optional long hold.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      out_ch.ready <= 1'b0;
      recv_hold    <= recv_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_byte !== want.read_byte)
          report_mismatch("read_byte", out_ch.read_byte, want.read_byte);
        if (out_ch.was_written !== want.was_written)
          report_mismatch("was_written", out_ch.was_written, want.was_written);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
      end
    end
  end

  // Watchdog on cycles without any accepted item while work is outstanding.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_results.size() == 0 && !in_ch.valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("timeout waiting for the block");
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_CHECK_DUP;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_WRITE;
    in_ch.byte_address = '0;
    in_ch.write_byte   = '0;
    out_ch.ready       = 1'b0;
    error_count        = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    recv_hold          = 0;
    quiet_cycles       = 0;
    shadow_pages       = 0;
    hit_valid          = 1'b0;
    hit_tag            = '0;
    hit_slot           = '0;
    check_dup          = 1'b0;
    allow_ovr          = 1'b0;
    for (int i = 0; i < MAX_PAGES*PAGE_BYTES; i++) shadow_marks[i] = 1'b0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int t = 2; t < TAG_POOL; t++) tag_pool[t] = TAG_W'($urandom);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    run_random(150, 40);
    test_duplicates();
    test_idling();
    test_backpressure();
    test_table_full();
    drain();

    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
